// ----- src/mtrc_pkg.sv -----
// Package for the temporal reference checker: command and picture-kind codes,
// default sizes, and the request/result structs passed between stages.
// No dependencies.
`timescale 1ns / 1ps

package mtrc_pkg;

  localparam int REF_BITS_DEF   = 10;
  localparam int COUNT_BITS_DEF = 16;
  localparam int TREF_W         = 10;
  localparam int ERR_W          = 16;
  localparam int CMD_W          = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_GOP   = 3'd0,
    CMD_PIC_I = 3'd1,
    CMD_PIC_P = 3'd2,
    CMD_PIC_B = 3'd3,
    CMD_END   = 3'd4,
    CMD_OTHER = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_I    = 2'd1,
    KIND_P    = 2'd2,
    KIND_B    = 2'd3
  } kind_e;

  // One parsed payload request; cmd stays raw so undefined codes pass through.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TREF_W-1:0] temporal_ref;
    logic              gop_closed;
    logic              gop_bad;
  } req_t;

  typedef struct packed {
    logic             status;
    logic [ERR_W-1:0] error_count;
  } res_t;

endpackage

// ----- src/mtrc_in_reg.sv -----
// Input register stage of the temporal reference checker.
// Holds one request until the checker core takes it. Uses mtrc_pkg.
`timescale 1ns / 1ps

module mtrc_in_reg
  import mtrc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  req_t req_i,
  output logic valid_o,
  output req_t req_o,
  input  logic take_i
);

  logic vld_q, vld_d;
  req_t req_q;

  // Refill in the same cycle the held request drains.
  assign ready_o = !vld_q || take_i;
  assign vld_d   = (valid_i && ready_o) ? 1'b1 : (take_i ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      req_q <= req_i;
    end
  end

  assign valid_o = vld_q;
  assign req_o   = req_q;

endmodule

// ----- src/mtrc_core.sv -----
// Checker core: sequence state registers and the combinational update logic.
// Takes a request when the result slot can accept any result it causes. Uses mtrc_pkg.
`timescale 1ns / 1ps

module mtrc_core
  import mtrc_pkg::*;
#(
  parameter int REF_BITS   = REF_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  req_t req_i,
  output logic take_o,
  input  logic res_free_i,
  output logic res_load_o,
  output res_t res_o
);

  localparam int CMP_W = ((REF_BITS > COUNT_BITS) ? REF_BITS : COUNT_BITS) + 1;

  logic                  seen_gop_q, seen_gop_d;
  logic                  closed_q, closed_d;
  logic                  seen_i_q, seen_i_d;
  logic                  seen_p_q, seen_p_d;
  logic                  seen_b_q, seen_b_d;
  kind_e                 kind_q, kind_d;
  logic [REF_BITS-1:0]   held_q, held_d;
  logic [COUNT_BITS-1:0] frame_q, frame_d;
  logic [COUNT_BITS-1:0] run_q, run_d;
  logic [COUNT_BITS-1:0] total_q, total_d;

  logic                  need_res;
  logic                  err;
  logic                  clr;
  logic                  is_i, is_p;
  logic [REF_BITS-1:0]   ref_v;
  logic [COUNT_BITS-1:0] total_inc;
  logic [COUNT_BITS-1:0] b_diff;

  assign need_res   = (req_i.cmd == CMD_END) || ((req_i.cmd == CMD_GOP) && req_i.gop_bad);
  assign take_o     = valid_i && (!need_res || res_free_i);
  assign res_load_o = take_o && need_res;

  always_comb begin
    seen_gop_d = seen_gop_q;
    closed_d   = closed_q;
    seen_i_d   = seen_i_q;
    seen_p_d   = seen_p_q;
    seen_b_d   = seen_b_q;
    kind_d     = kind_q;
    held_d     = held_q;
    frame_d    = frame_q;
    run_d      = run_q;
    err        = 1'b0;
    clr        = 1'b0;
    is_i       = (req_i.cmd == CMD_PIC_I);
    is_p       = (req_i.cmd == CMD_PIC_P);
    ref_v      = REF_BITS'(req_i.temporal_ref);
    b_diff     = '0;

    case (req_i.cmd)
      CMD_GOP: begin
        if (req_i.gop_bad) begin
          clr = 1'b1;
        end else begin
          if (seen_gop_q) begin
            seen_i_d = 1'b0;
            seen_p_d = 1'b0;
            seen_b_d = 1'b0;
            frame_d  = '0;
          end
          seen_gop_d = 1'b1;
          closed_d   = req_i.gop_closed;
        end
      end
      CMD_END: begin
        frame_d = frame_q + 1'b1;
        if ((kind_q != KIND_NONE) && (CMP_W'(held_q) != CMP_W'(frame_d))) begin
          err = 1'b1;
        end
        clr = 1'b1;
      end
      CMD_PIC_I, CMD_PIC_P, CMD_PIC_B: begin
        if (seen_gop_q) begin
          // First I of the group.
          if (is_i && !seen_i_q) begin
            if (closed_q) begin
              if (ref_v != '0) begin
                err = 1'b1;
              end
              frame_d = '0;
            end else begin
              held_d = ref_v;
            end
            seen_i_d = 1'b1;
            kind_d   = KIND_I;
          end
          // First P after the I, or a later anchor picture.
          if (is_p && seen_i_d && !seen_p_q) begin
            if (!closed_q) begin
              frame_d = frame_d + 1'b1;
              if (CMP_W'(held_d) != CMP_W'(frame_d)) begin
                err = 1'b1;
              end
            end
            held_d   = ref_v;
            seen_p_d = 1'b1;
            kind_d   = KIND_P;
          end else if ((is_i || is_p) && seen_i_d && seen_p_q) begin
            frame_d = frame_d + 1'b1;
            run_d   = (kind_d == KIND_B) ? '0 : run_d + 1'b1;
            if (run_d != '0) begin
              if ((REF_BITS + 1)'(held_d) + 1'b1 != (REF_BITS + 1)'(ref_v)) begin
                err = 1'b1;
              end
            end else if (CMP_W'(held_d) != CMP_W'(frame_d)) begin
              err = 1'b1;
            end
            held_d = ref_v;
            kind_d = KIND_P;
          end
          // B picture: advance or restart the frame counter, then check.
          if (req_i.cmd == CMD_PIC_B) begin
            if (!seen_b_q && closed_q) begin
              frame_d  = frame_d + 1'b1;
              closed_d = 1'b0;
              seen_b_d = 1'b1;
            end else if (seen_b_q && !closed_q) begin
              frame_d = frame_d + 1'b1;
            end else if (!seen_b_q && !closed_q) begin
              frame_d  = '0;
              seen_b_d = 1'b1;
            end
            b_diff = frame_d - run_d;
            if ((run_d > frame_d) || (CMP_W'(ref_v) != CMP_W'(b_diff))) begin
              err = 1'b1;
            end
            kind_d = KIND_B;
          end
        end
      end
      default: begin
      end
    endcase

    total_inc = (err && (total_q != '1)) ? total_q + 1'b1 : total_q;
    total_d   = total_inc;

    if (clr) begin
      seen_gop_d = 1'b0;
      closed_d   = 1'b0;
      seen_i_d   = 1'b0;
      seen_p_d   = 1'b0;
      seen_b_d   = 1'b0;
      kind_d     = KIND_NONE;
      held_d     = '0;
      frame_d    = '0;
      run_d      = '0;
      total_d    = '0;
    end

    res_o.status = (req_i.cmd == CMD_GOP);
    if (req_i.cmd == CMD_GOP) begin
      res_o.error_count = '0;
    end else if ((total_inc >> ERR_W) != '0) begin
      res_o.error_count = '1;
    end else begin
      res_o.error_count = ERR_W'(total_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_gop_q <= 1'b0;
      closed_q   <= 1'b0;
      seen_i_q   <= 1'b0;
      seen_p_q   <= 1'b0;
      seen_b_q   <= 1'b0;
      kind_q     <= KIND_NONE;
      held_q     <= '0;
      frame_q    <= '0;
      run_q      <= '0;
      total_q    <= '0;
    end else if (take_o) begin
      seen_gop_q <= seen_gop_d;
      closed_q   <= closed_d;
      seen_i_q   <= seen_i_d;
      seen_p_q   <= seen_p_d;
      seen_b_q   <= seen_b_d;
      kind_q     <= kind_d;
      held_q     <= held_d;
      frame_q    <= frame_d;
      run_q      <= run_d;
      total_q    <= total_d;
    end
  end

endmodule

// ----- src/mtrc_out_reg.sv -----
// Result register of the temporal reference checker.
// Holds one result until the consumer takes it. Uses mtrc_pkg.
`timescale 1ns / 1ps

module mtrc_out_reg
  import mtrc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  output logic free_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o
);

  logic vld_q, vld_d;
  res_t res_q;

  assign free_o = !vld_q || ready_i;
  assign vld_d  = load_i ? 1'b1 : (ready_i ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

// ----- src/mpeg_temporal_ref_checker_top.sv -----
// Top level of the MPEG-2 temporal reference checker.
// Throughput: one request per cycle while results drain; a request that causes a
//   result waits in the input register while an earlier result is still held.
// Path: an accepted request is held in the input register; once the core takes it,
//   its result is loaded into the result register and held there until taken.
// Reset: rst_ni clears all sequence state and both valid flags at once.
// Depends on mtrc_pkg, mtrc_in_reg, mtrc_core and mtrc_out_reg.
`timescale 1ns / 1ps

module mpeg_temporal_ref_checker_top
  import mtrc_pkg::*;
#(
  parameter int REF_BITS   = REF_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Request channel: one parsed payload per request.
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [TREF_W-1:0] temporal_ref_i,
  input  logic              gop_closed_i,
  input  logic              gop_bad_i,
  // Result channel: end-of-sequence totals and bad-GOP aborts.
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              status_o,
  output logic [ERR_W-1:0]  error_count_o
);

  req_t req_in;
  req_t req_held;
  logic req_vld;
  logic req_take;
  logic res_free;
  logic res_load;
  res_t res_next;
  res_t res_out;

  // Pack the request fields.
  assign req_in.cmd          = cmd_i;
  assign req_in.temporal_ref = temporal_ref_i;
  assign req_in.gop_closed   = gop_closed_i;
  assign req_in.gop_bad      = gop_bad_i;

  // Input register: accepts a new request when empty or when the held one drains.
  mtrc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .req_i   (req_in),
    .valid_o (req_vld),
    .req_o   (req_held),
    .take_i  (req_take)
  );

  // Core: update sequence state; stall only when a result has no slot.
  mtrc_core #(
    .REF_BITS   (REF_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (req_vld),
    .req_i      (req_held),
    .take_o     (req_take),
    .res_free_i (res_free),
    .res_load_o (res_load),
    .res_o      (res_next)
  );

  // Result register: hold each result until the consumer takes it.
  mtrc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_load),
    .res_i   (res_next),
    .free_o  (res_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res_out)
  );

  assign status_o      = res_out.status;
  assign error_count_o = res_out.error_count;

endmodule
